>>> design/quadratic_root_solver_defines.svh
// Assertion macros used by the solver module.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define QRS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define QRS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> design/qrs_pkg.sv
package qrs_pkg;

	typedef enum logic [2:0] {
		ST_INFINITE = 3'd0,
		ST_NONE     = 3'd1,
		ST_NOREAL   = 3'd2,
		ST_LINEAR   = 3'd3,
		ST_DOUBLE   = 3'd4,
		ST_TWO      = 3'd5
	} status_t;

	typedef struct packed {
		logic signed [15:0] coef_a;
		logic signed [15:0] coef_b;
		logic signed [15:0] coef_c;
	} coef_t;

	typedef struct packed {
		logic [2:0]         solve_status;
		logic signed [31:0] root_first;
		logic signed [31:0] root_second;
		logic               root_saturated;
	} result_t;

	// Radicand Dn * 2^30 fits in 64 bits; root is 32 bits.
	localparam int RadW   = 64;
	localparam int RootW  = 32;
	// Dividends reach 2^32 magnitude; divisor magnitude at most 2^15.
	localparam int NumW   = 34;
	localparam int DenW   = 16;
	localparam int QuoW   = 34;

	// Item context carried alongside the arithmetic chains.
	typedef struct packed {
		logic [2:0]            status;
		logic                  neg1;
		logic                  neg2;
		logic [NumW-1:0]       num1;
		logic [NumW-1:0]       num2;
		logic [DenW-1:0]       den;
		logic signed [33:0]    base;
		logic                  a_neg;
	} ctx_t;

	// Clip a signed quotient to the Q16.16 range.
	function automatic logic [32:0] clip32(input logic signed [QuoW:0] v);
		logic [32:0] r;
		if (v > 35'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -35'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

>>> design/qrs_sqrt_cell.sv
// One step of the digit-by-digit square root: two radicand bits per cell.
module qrs_sqrt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_in,
	input  logic [qrs_pkg::RadW-1:0] rem_in,
	input  logic [qrs_pkg::RadW-1:0] rad_in,
	input  logic [qrs_pkg::RootW-1:0] root_in,
	input  qrs_pkg::ctx_t            ctx_in,
	output logic                     vld_out,
	output logic [qrs_pkg::RadW-1:0] rem_out,
	output logic [qrs_pkg::RadW-1:0] rad_out,
	output logic [qrs_pkg::RootW-1:0] root_out,
	output qrs_pkg::ctx_t            ctx_out
);
	import qrs_pkg::*;

	logic [RadW+1:0] trial;
	logic [RadW+1:0] rem_sh;
	logic            take;

	// Bring down two radicand bits and try root*4+1.
	always_comb begin
		rem_sh = {rem_in, rad_in[RadW-1 -: 2]};
		trial  = (RadW+2)'({root_in, 2'b01});
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out  <= take ? RadW'(rem_sh - trial) : rem_sh[RadW-1:0];
		rad_out  <= {rad_in[RadW-3:0], 2'b00};
		root_out <= {root_in[RootW-2:0], take};
		ctx_out  <= ctx_in;
	end
endmodule

>>> design/qrs_div_cell.sv
// One restoring-division step for both root quotients.
module qrs_div_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_in,
	input  logic [qrs_pkg::NumW-1:0] rem1_in,
	input  logic [qrs_pkg::NumW-1:0] rem2_in,
	input  logic [qrs_pkg::QuoW-1:0] q1_in,
	input  logic [qrs_pkg::QuoW-1:0] q2_in,
	input  qrs_pkg::ctx_t            ctx_in,
	output logic                     vld_out,
	output logic [qrs_pkg::NumW-1:0] rem1_out,
	output logic [qrs_pkg::NumW-1:0] rem2_out,
	output logic [qrs_pkg::QuoW-1:0] q1_out,
	output logic [qrs_pkg::QuoW-1:0] q2_out,
	output qrs_pkg::ctx_t            ctx_out
);
	import qrs_pkg::*;

	logic [NumW:0] r1, r2, den_x;
	logic          t1, t2;
	ctx_t          ctx_nx;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		den_x = {{(NumW+1-DenW){1'b0}}, ctx_in.den};
		r1 = {rem1_in, ctx_in.num1[NumW-1]};
		r2 = {rem2_in, ctx_in.num2[NumW-1]};
		t1 = (r1 >= den_x);
		t2 = (r2 >= den_x);
		ctx_nx      = ctx_in;
		ctx_nx.num1 = {ctx_in.num1[NumW-2:0], 1'b0};
		ctx_nx.num2 = {ctx_in.num2[NumW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem1_out <= t1 ? NumW'(r1 - den_x) : r1[NumW-1:0];
		rem2_out <= t2 ? NumW'(r2 - den_x) : r2[NumW-1:0];
		q1_out   <= {q1_in[QuoW-2:0], t1};
		q2_out   <= {q2_in[QuoW-2:0], t2};
		ctx_out  <= ctx_nx;
	end
endmodule

>>> design/quadratic_root_solver.sv
// Channel   Dir  Signals                      Handshake
// command   in   start, busy, coef            taken when start & !busy
// result    out  result_valid, result         one-cycle strobe, no stall
//
// One item may enter every cycle; busy is held low.
// Each item passes through setup, one square-root cell per
// root bit, one divider cell per quotient bit, then sign and clip.
// Reset clears only the valid bits along the pipeline.
// The receiver cannot stall; each result appears exactly once.
`include "quadratic_root_solver_defines.svh"
module quadratic_root_solver (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  qrs_pkg::coef_t   coef,
	output logic             result_valid,
	output qrs_pkg::result_t result
);
	import qrs_pkg::*;

	localparam int SqN = RootW;
	localparam int DvN = NumW;

	logic                 acc;
	logic signed [31:0]   bb_s1;
	logic signed [33:0]   ac4_s1;
	logic signed [15:0]   a_s1, b_s1, c_s1;
	logic                 v_s1, v_s2;
	ctx_t                 ctx_s2;
	logic [RadW-1:0]      rad_s2;
	logic signed [33:0]   dn;

	logic                 sv   [0:SqN];
	logic [RadW-1:0]      srem [0:SqN];
	logic [RadW-1:0]      srad [0:SqN];
	logic [RootW-1:0]     sroot[0:SqN];
	ctx_t                 sctx [0:SqN];

	logic                 dv   [0:DvN];
	logic [NumW-1:0]      r1   [0:DvN];
	logic [NumW-1:0]      r2   [0:DvN];
	logic [QuoW-1:0]      q1   [0:DvN];
	logic [QuoW-1:0]      q2   [0:DvN];
	ctx_t                 dctx [0:DvN];

	ctx_t                 pre;
	logic signed [34:0]   n1, n2, sq;
	logic signed [QuoW:0] x1, x2;
	logic [32:0]          c1, c2;
	result_t              res_d;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	// Stage 1: the two products of the discriminant.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= coef.coef_a;
		b_s1   <= coef.coef_b;
		c_s1   <= coef.coef_c;
		bb_s1  <= 32'(coef.coef_b * coef.coef_b);
		ac4_s1 <= 34'(coef.coef_a * coef.coef_c) <<< 2;
	end

	// Stage 2: classify and build radicand and dividend context.
	always_comb begin
		logic signed [33:0] lin;
		dn  = 34'(bb_s1) - ac4_s1;
		pre = '0;
		pre.base  = -(34'(b_s1) <<< 15);
		pre.a_neg = a_s1[15];
		lin = -(34'(c_s1) <<< 16);
		if (a_s1 == 0 && b_s1 == 0 && c_s1 == 0) begin
			pre.status = ST_INFINITE;
		end else if (a_s1 == 0 && b_s1 == 0) begin
			pre.status = ST_NONE;
		end else if (a_s1 == 0) begin
			pre.status = ST_LINEAR;
			pre.base   = lin;
			pre.a_neg  = b_s1[15];
			pre.den    = b_s1[15] ? DenW'(-b_s1) : DenW'(b_s1);
		end else if (dn < 0) begin
			pre.status = ST_NOREAL;
		end else if (dn == 0) begin
			pre.status = ST_DOUBLE;
			pre.den    = a_s1[15] ? DenW'(-a_s1) : DenW'(a_s1);
		end else begin
			pre.status = ST_TWO;
			pre.den    = a_s1[15] ? DenW'(-a_s1) : DenW'(a_s1);
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= pre;
		rad_s2 <= (pre.status == ST_TWO) ? (RadW'(dn[32:0]) << 30) : '0;
	end

	// Square-root chain.
	assign sv[0]    = v_s2;
	assign srem[0]  = '0;
	assign srad[0]  = rad_s2;
	assign sroot[0] = '0;
	assign sctx[0]  = ctx_s2;

	for (genvar i = 0; i < SqN; i++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_in(sv[i]), .rem_in(srem[i]), .rad_in(srad[i]),
			.root_in(sroot[i]), .ctx_in(sctx[i]),
			.vld_out(sv[i+1]), .rem_out(srem[i+1]), .rad_out(srad[i+1]),
			.root_out(sroot[i+1]), .ctx_out(sctx[i+1])
		);
	end

	// Form both signed numerators and split off their signs.
	always_comb begin
		sq = 35'(sroot[SqN]);
		n1 = 35'(sctx[SqN].base) - sq;
		n2 = 35'(sctx[SqN].base) + sq;
		dctx[0]      = sctx[SqN];
		dctx[0].neg1 = n1[34] ^ sctx[SqN].a_neg;
		dctx[0].neg2 = n2[34] ^ sctx[SqN].a_neg;
		dctx[0].num1 = n1[34] ? NumW'(-n1) : NumW'(n1);
		dctx[0].num2 = n2[34] ? NumW'(-n2) : NumW'(n2);
	end

	assign dv[0] = sv[SqN];
	assign r1[0] = '0;
	assign r2[0] = '0;
	assign q1[0] = '0;
	assign q2[0] = '0;

	// Divider chain.
	for (genvar j = 0; j < DvN; j++) begin : g_dv
		qrs_div_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.vld_in(dv[j]), .rem1_in(r1[j]), .rem2_in(r2[j]),
			.q1_in(q1[j]), .q2_in(q2[j]), .ctx_in(dctx[j]),
			.vld_out(dv[j+1]), .rem1_out(r1[j+1]), .rem2_out(r2[j+1]),
			.q1_out(q1[j+1]), .q2_out(q2[j+1]), .ctx_out(dctx[j+1])
		);
	end

	// Apply signs, clip, and select by status.
	always_comb begin
		x1 = dctx[DvN].neg1 ? -$signed({1'b0, q1[DvN]}) : $signed({1'b0, q1[DvN]});
		x2 = dctx[DvN].neg2 ? -$signed({1'b0, q2[DvN]}) : $signed({1'b0, q2[DvN]});
		c1 = clip32(x1);
		c2 = clip32(x2);
		res_d = '0;
		res_d.solve_status = dctx[DvN].status;
		case (dctx[DvN].status) inside
			ST_LINEAR, ST_DOUBLE: begin
				res_d.root_first     = c1[31:0];
				res_d.root_saturated = c1[32];
			end
			ST_TWO: begin
				res_d.root_first     = c1[31:0];
				res_d.root_second    = c2[31:0];
				res_d.root_saturated = c1[32] | c2[32];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dv[DvN];
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

	`QRS_ASSERT_IMP(a_busy_low, clk, arst_n, 1'b1, !busy, "busy must stay low")
	`QRS_ASSERT_NEXT(a_s1_follows, clk, arst_n, acc, v_s1, "accepted item lost at stage 1")
	`QRS_ASSERT_IMP(a_status_range, clk, arst_n, result_valid,
		result.solve_status <= ST_TWO, "status out of range")
	`QRS_ASSERT_IMP(a_second_zero, clk, arst_n,
		result_valid && result.solve_status != ST_TWO,
		result.root_second == 0, "second root must be zero")
endmodule
